[rtl/core/sbsh_pkg.sv]
package sbsh_pkg;

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_ABSORB  = 2'd0,
        CMD_FINISH  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } t_out_item;

    // queue to engine hand-over
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

endpackage

[rtl/core/sbsh_fifo.sv]
module sbsh_fifo
    import sbsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output t_queue_head o_head,
    input  logic        i_pop
);

    localparam int AW = $clog2(FIFO_DEPTH);

    t_in_item         r_mem [FIFO_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             push, pop;

    assign o_stall     = (r_cnt == (AW+1)'(FIFO_DEPTH));
    assign push        = i_valid && !o_stall;
    assign pop         = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

[rtl/core/sbsh_engine.sv]
module sbsh_engine
    import sbsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);

    t_state        r_state, n_state;
    logic [31:0]   r_chain [8];
    logic [31:0]   n_chain [8];
    logic [31:0]   r_v [8];
    logic [31:0]   n_v [8];
    logic [511:0]  r_blk, n_blk;
    logic [5:0]    r_fill, n_fill;
    logic [63:0]   r_bits, n_bits;
    logic [5:0]    r_rnd, n_rnd;
    logic          r_fin, n_fin;
    logic          r_len_ok, n_len_ok;
    logic          r_first, n_first;
    logic [2:0]    r_idx, n_idx;

    logic [31:0]   w0, w1, w9, w14, w_new, s0, s1;
    logic [31:0]   bs0, bs1, chs, mj, p, q;
    logic [7:0]    pad_byte, len_byte;

    // schedule window: word 0 sits in the top bits
    always_comb begin
        w0    = r_blk[511:480];
        w1    = r_blk[479:448];
        w9    = r_blk[223:192];
        w14   = r_blk[63:32];
        s0    = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
        s1    = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
        w_new = w0 + s0 + w9 + s1;
        bs1   = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        chs   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        bs0   = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        mj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        p     = r_v[7] + bs1 + chs + K_TAB[r_rnd] + w0;
        q     = bs0 + mj;
        len_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
        if (r_first) begin
            pad_byte = PAD_MARK;
        end else if (r_len_ok && r_fill >= LEN_POS) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_chain  = r_chain;
        n_v      = r_v;
        n_blk    = r_blk;
        n_fill   = r_fill;
        n_bits   = r_bits;
        n_rnd    = r_rnd;
        n_fin    = r_fin;
        n_len_ok = r_len_ok;
        n_first  = r_first;
        n_idx    = r_idx;
        o_pop    = 1'b0;
        o_valid  = 1'b0;
        o_item.digest_word = r_chain[r_idx];
        o_item.last_word   = (r_idx == 3'd7);
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (t_cmd'(i_head.item.command))
                        CMD_ABSORB: begin
                            n_blk  = {r_blk[503:0], i_head.item.data_byte};
                            n_fill = r_fill + 1'b1;
                            n_bits = r_bits + 64'd8;
                            if (r_fill == 6'd63) begin
                                n_v     = r_chain;
                                n_rnd   = '0;
                                n_state = ST_ROUND;
                            end
                        end
                        CMD_FINISH: begin
                            n_fin    = 1'b1;
                            n_first  = 1'b1;
                            n_len_ok = 1'b0;
                            n_state  = ST_PAD;
                        end
                        CMD_RESTART: begin
                            n_chain = IV;
                            n_fill  = '0;
                            n_bits  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAD: begin
                n_blk   = {r_blk[503:0], pad_byte};
                n_fill  = r_fill + 1'b1;
                n_first = 1'b0;
                if (r_first) begin
                    n_len_ok = (r_fill < LEN_POS);
                end
                if (r_fill == 6'd63) begin
                    n_v     = r_chain;
                    n_rnd   = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + p;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = p + q;
                n_blk  = {r_blk[479:0], w_new};
                n_rnd  = r_rnd + 1'b1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_len_ok) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_len_ok = 1'b1;
                    n_state  = ST_PAD;
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd7) begin
                        n_chain = IV;
                        n_fill  = '0;
                        n_bits  = '0;
                        n_fin   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= IV;
            r_fill   <= '0;
            r_bits   <= '0;
            r_rnd    <= '0;
            r_fin    <= 1'b0;
            r_len_ok <= 1'b0;
            r_first  <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_rnd    <= n_rnd;
            r_fin    <= n_fin;
            r_len_ok <= n_len_ok;
            r_first  <= n_first;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_blk <= n_blk;
    end

    a_emit_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EMIT ##1 r_state == ST_EMIT) |-> $past(r_state) == ST_ADD)
        else $error("digest shown without a final add");

    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND ##1 r_state == ST_ROUND) |-> r_rnd == 6'd0)
        else $error("compression entered mid-count");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && i_head.valid))
        else $error("queue popped while busy");

endmodule

[rtl/core/sha256_byte_stream_hasher_unit.sv]
// SHA-256 over a byte stream. Each input beat carries a command: absorb one
// byte, finish (pad, compress, then deliver the digest as eight 32-bit
// big-endian word beats, last_word set on the eighth), or restart. Beats
// land in a four-deep queue, so the sender is only stalled when it is full;
// an engine behind it works one command at a time. Every 64th absorbed byte
// adds 64 compression rounds and the chaining add, and the engine takes no
// new byte until they are done. Finish pads one byte per cycle up to the
// block end (twice if more than 55 bytes are buffered), compresses, then
// holds each digest word until taken. The chaining state returns to the
// initial vector after the digest.
module sha256_byte_stream_hasher_unit
    import sbsh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_queue_head head;
    logic        pop;

    // front: command queue
    sbsh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_head  (head),
        .i_pop   (pop)
    );

    // back: padding, compression and digest beats
    sbsh_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
